[hw/rtl/dilp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dilp_pkg;

  // field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 16;
  localparam int unsigned KindW  = 2;
  localparam int unsigned ArgsW  = 7;

  // list encoding
  localparam logic [ByteW-1:0]  DelayFlag      = 8'h80;
  localparam logic [ByteW-1:0]  LongDelayCode  = 8'd255;
  localparam logic [ValueW-1:0] LongDelayReset = 16'd500;

  // item kinds
  localparam logic [KindW-1:0] KindCmd   = 2'd0;
  localparam logic [KindW-1:0] KindArg   = 2'd1;
  localparam logic [KindW-1:0] KindDelay = 2'd2;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] value;
    logic              frame_end;
    logic              list_done;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/dilp_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module dilp_parser (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            accept,
  input  wire  [dilp_pkg::ByteW-1:0]     list_byte,
  input  wire  [dilp_pkg::ValueW-1:0]    long_delay_ms,
  output logic                           res_valid,
  output dilp_pkg::result_t              res
);

  typedef enum logic [2:0] {
    PH_COUNT = 3'd0,
    PH_CMD   = 3'd1,
    PH_NARGS = 3'd2,
    PH_ARGS  = 3'd3,
    PH_DELAY = 3'd4
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [dilp_pkg::ByteW-1:0]    cmds_left_r, cmds_left_nxt;
  logic [dilp_pkg::ArgsW-1:0]    args_left_r, args_left_nxt;
  logic                          delay_pend_r, delay_pend_nxt;
  logic [dilp_pkg::ByteW-1:0]    held_cmd_r, held_cmd_nxt;

  logic                          last_cmd;
  logic [dilp_pkg::ByteW-1:0]    cmds_dec;
  logic [dilp_pkg::ArgsW-1:0]    nargs;
  logic [dilp_pkg::ArgsW-1:0]    args_dec;
  logic [dilp_pkg::ValueW-1:0]   byte_ext;

  // command bookkeeping shared by every end of a command
  assign last_cmd = (cmds_left_r <= 8'd1);
  assign cmds_dec = cmds_left_r - ((cmds_left_r != '0) ? 8'd1 : 8'd0);
  assign nargs    = list_byte[dilp_pkg::ArgsW-1:0];
  assign args_dec = args_left_r - 7'd1;
  assign byte_ext = {8'd0, list_byte};

  // next state and result for the byte on the input
  always_comb begin
    phase_nxt      = phase_r;
    cmds_left_nxt  = cmds_left_r;
    args_left_nxt  = args_left_r;
    delay_pend_nxt = delay_pend_r;
    held_cmd_nxt   = held_cmd_r;
    res_valid      = 1'b0;
    res.kind       = dilp_pkg::KindCmd;
    res.value      = byte_ext;
    res.frame_end  = 1'b0;
    res.list_done  = 1'b0;
    case (phase_r)
      PH_CMD: begin
        held_cmd_nxt = list_byte;
        phase_nxt    = PH_NARGS;
      end
      PH_NARGS: begin
        args_left_nxt  = nargs;
        delay_pend_nxt = (list_byte & dilp_pkg::DelayFlag) != '0;
        res_valid      = 1'b1;
        res.kind       = dilp_pkg::KindCmd;
        res.value      = {8'd0, held_cmd_r};
        if (nargs != '0) begin
          phase_nxt = PH_ARGS;
        end else if ((list_byte & dilp_pkg::DelayFlag) != '0) begin
          phase_nxt     = PH_DELAY;
          res.frame_end = 1'b1;
        end else begin
          cmds_left_nxt = cmds_dec;
          phase_nxt     = last_cmd ? PH_COUNT : PH_CMD;
          res.frame_end = 1'b1;
          res.list_done = last_cmd;
        end
      end
      PH_ARGS: begin
        args_left_nxt = args_dec;
        res_valid     = 1'b1;
        res.kind      = dilp_pkg::KindArg;
        if (args_dec != '0) begin
          res.frame_end = 1'b0;
        end else if (delay_pend_r) begin
          phase_nxt     = PH_DELAY;
          res.frame_end = 1'b1;
        end else begin
          cmds_left_nxt = cmds_dec;
          phase_nxt     = last_cmd ? PH_COUNT : PH_CMD;
          res.frame_end = 1'b1;
          res.list_done = last_cmd;
        end
      end
      PH_DELAY: begin
        delay_pend_nxt = 1'b0;
        cmds_left_nxt  = cmds_dec;
        phase_nxt      = last_cmd ? PH_COUNT : PH_CMD;
        res_valid      = 1'b1;
        res.kind       = dilp_pkg::KindDelay;
        res.value      = (list_byte == dilp_pkg::LongDelayCode) ? long_delay_ms : byte_ext;
        res.list_done  = last_cmd;
      end
      default: begin
        cmds_left_nxt  = list_byte;
        args_left_nxt  = '0;
        delay_pend_nxt = 1'b0;
        phase_nxt      = (list_byte != '0) ? PH_CMD : PH_COUNT;
      end
    endcase
  end

  // parse state, advanced once per accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_COUNT;
      cmds_left_r  <= '0;
      args_left_r  <= '0;
      delay_pend_r <= 1'b0;
      held_cmd_r   <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      cmds_left_r  <= cmds_left_nxt;
      args_left_r  <= args_left_nxt;
      delay_pend_r <= delay_pend_nxt;
      held_cmd_r   <= held_cmd_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/display_init_list_player_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Display init list player: takes an init command list one byte per item
// (count, then per command a command byte, an argument-count byte with bit 7
// asking for a delay, the arguments, an optional delay byte) and gives one
// item per command byte, argument byte and delay request. The parse state
// updates in the accepting cycle and the result lands in the output or skid
// register, so a byte can be accepted every cycle while in_tready is high.
// A two-entry output buffer (output register plus skid register) lets one
// more byte in while a result waits; in_tready drops only when both are
// full. Configuration is written through cfg_* (always ready) while idle.

module display_init_list_player_top (
  input  wire         clk,
  input  wire         rst_n,
  // configuration: long_delay_ms
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [15:0] cfg_data,
  // list byte input
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] list_byte
  // result output
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [15:0] item_value
  output logic [2:0]  out_tuser,  // [1:0] item_kind, [2] list_done
  output logic        out_tlast   // frame_end
);

  logic [dilp_pkg::ValueW-1:0] long_delay_r;
  logic                        accept;
  logic                        res_valid;
  dilp_pkg::result_t           res;

  logic                        out_vld_r, out_vld_nxt;
  dilp_pkg::result_t           out_res_r, out_res_nxt;
  logic                        skd_vld_r, skd_vld_nxt;
  dilp_pkg::result_t           skd_res_r, skd_res_nxt;
  logic                        out_free;

  // config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_delay_r <= dilp_pkg::LongDelayReset;
    end else if (cfg_valid) begin
      long_delay_r <= cfg_data;
    end
  end

  assign in_tready = !skd_vld_r;
  assign accept    = in_tvalid && in_tready;

  dilp_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .list_byte     (in_tdata),
    .long_delay_ms (long_delay_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  // output register plus skid
  assign out_free = !out_vld_r || out_tready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    skd_vld_nxt = skd_vld_r;
    skd_res_nxt = skd_res_r;
    if (out_free) begin
      if (skd_vld_r) begin
        out_vld_nxt = 1'b1;
        out_res_nxt = skd_res_r;
        skd_vld_nxt = 1'b0;
      end else if (accept && res_valid) begin
        out_vld_nxt = 1'b1;
        out_res_nxt = res;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end else if (accept && res_valid) begin
      skd_vld_nxt = 1'b1;
      skd_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skd_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      skd_vld_r <= skd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    skd_res_r <= skd_res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_res_r.value;
  assign out_tuser  = {out_res_r.list_done, out_res_r.kind};
  assign out_tlast  = out_res_r.frame_end;

endmodule

`default_nettype wire

[hw/rtl/dilp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module dilp_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        out_tvalid,
  input  wire        out_tready,
  input  wire [15:0] out_tdata,
  input  wire [2:0]  out_tuser,
  input  wire        out_tlast
);

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled item changed");

  // kind is one of command, argument, delay
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[1:0] == dilp_pkg::KindCmd ||
                    out_tuser[1:0] == dilp_pkg::KindArg ||
                    out_tuser[1:0] == dilp_pkg::KindDelay))
    else $error("bad item kind");

  // a delay request never closes a frame
  a_delay_no_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == dilp_pkg::KindDelay |-> !out_tlast)
    else $error("frame end on delay request");

  // list end on a byte item also ends the frame
  a_done_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] && out_tuser[1:0] != dilp_pkg::KindDelay |-> out_tlast)
    else $error("list done without frame end");

endmodule

bind display_init_list_player_top dilp_checker u_dilp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[tb/tb_display_init_list_player_top.sv]
`timescale 1ns / 1ps

module tb_display_init_list_player_top;

  localparam int CycleLimit   = 400000;
  localparam int PhaseItems   = 150;
  localparam int HoldAfter    = 60;
  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 4;

  typedef enum logic [2:0] {
    PhCount,
    PhCmd,
    PhNargs,
    PhArgs,
    PhDelay
  } list_phase_t;

  // list parser mirror plus the queue of items the block still owes
  class init_list_board;
    dilp_pkg::result_t owed_q[$];
    list_phase_t       phase;
    logic [7:0]        cmds_left;
    logic [6:0]        args_left;
    logic              delay_due;
    logic [7:0]        held_cmd;
    logic [15:0]       long_delay;
    int                mismatches;

    function new();
      phase      = PhCount;
      cmds_left  = '0;
      args_left  = '0;
      delay_due  = 1'b0;
      held_cmd   = '0;
      long_delay = dilp_pkg::LongDelayReset;
      mismatches = 0;
    endfunction

    function void set_long_delay(logic [15:0] ms);
      long_delay = ms;
    endfunction

    function void owe(logic [dilp_pkg::KindW-1:0] kind, logic [15:0] value,
                      logic fe, logic done);
      dilp_pkg::result_t r;
      r.kind      = kind;
      r.value     = value;
      r.frame_end = fe;
      r.list_done = done;
      owed_q.push_back(r);
    endfunction

    // closes the current command, returns 1 when it was the last of the list
    function logic close_command();
      logic last;
      last = (cmds_left <= 8'd1);
      if (cmds_left != 8'd0) cmds_left = cmds_left - 8'd1;
      phase = last ? PhCount : PhCmd;
      return last;
    endfunction

    function void note_byte(logic [7:0] list_byte);
      logic done;
      case (phase)
        PhCmd: begin
          held_cmd = list_byte;
          phase    = PhNargs;
        end
        PhNargs: begin
          args_left = list_byte[6:0];
          delay_due = ((list_byte & dilp_pkg::DelayFlag) != 8'h00);
          if (args_left != 7'd0) begin
            phase = PhArgs;
            owe(dilp_pkg::KindCmd, {8'h00, held_cmd}, 1'b0, 1'b0);
          end else if (delay_due) begin
            phase = PhDelay;
            owe(dilp_pkg::KindCmd, {8'h00, held_cmd}, 1'b1, 1'b0);
          end else begin
            done = close_command();
            owe(dilp_pkg::KindCmd, {8'h00, held_cmd}, 1'b1, done);
          end
        end
        PhArgs: begin
          args_left = args_left - 7'd1;
          if (args_left != 7'd0) begin
            owe(dilp_pkg::KindArg, {8'h00, list_byte}, 1'b0, 1'b0);
          end else if (delay_due) begin
            phase = PhDelay;
            owe(dilp_pkg::KindArg, {8'h00, list_byte}, 1'b1, 1'b0);
          end else begin
            done = close_command();
            owe(dilp_pkg::KindArg, {8'h00, list_byte}, 1'b1, done);
          end
        end
        PhDelay: begin
          delay_due = 1'b0;
          done      = close_command();
          owe(dilp_pkg::KindDelay,
              (list_byte == dilp_pkg::LongDelayCode) ? long_delay : {8'h00, list_byte},
              1'b0, done);
        end
        default: begin
          cmds_left = list_byte;
          args_left = '0;
          delay_due = 1'b0;
          phase     = (list_byte != 8'h00) ? PhCmd : PhCount;
        end
      endcase
    endfunction

    function void check_result(dilp_pkg::result_t got);
      dilp_pkg::result_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: kind %0d value %0h last %0b done %0b",
                   got.kind, got.value, got.frame_end, got.list_done);
        return;
      end
      want = owed_q.pop_front();
      if (got.kind !== want.kind || got.value !== want.value ||
          got.frame_end !== want.frame_end || got.list_done !== want.list_done) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"item mismatch: want kind %0d value %0h last %0b done %0b, ",
                    "got kind %0d value %0h last %0b done %0b"},
                   want.kind, want.value, want.frame_end, want.list_done,
                   got.kind, got.value, got.frame_end, got.list_done);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] list_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] item_value
  logic [2:0]  out_tuser;  // [1:0] item_kind, [2] list_done
  logic        out_tlast;  // frame_end

  init_list_board board;
  int             cycles = 0;
  int             bytes_sent;
  int             items_seen = 0;
  logic           no_idle;
  logic           hold_done = 1'b0;

  display_init_list_player_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // one list byte per item, with a random gap before it
  task automatic send_byte(input logic [7:0] list_byte);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= list_byte;
    do @(posedge clk); while (!in_tready);
    board.note_byte(list_byte);
    bytes_sent++;
  endtask

  // stop offering, let every owed item drain, then let the parser settle
  task automatic drain_items();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.owed_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_long_delay(input logic [15:0] ms);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= ms;
    do @(posedge clk); while (!cfg_ready);
    board.set_long_delay(ms);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // well-formed list with random content, mostly short frames
  task automatic send_random_list(input int n_cmds);
    int       n_args;
    logic     with_delay;
    send_byte(8'(n_cmds));
    for (int c = 0; c < n_cmds; c++) begin
      send_byte(8'($urandom_range(0, 255)));
      n_args     = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 127)
                                                : $urandom_range(0, 4);
      with_delay = 1'($urandom_range(0, 1));
      send_byte({with_delay, 7'(n_args)});
      for (int a = 0; a < n_args; a++) send_byte(8'($urandom_range(0, 255)));
      if (with_delay)
        send_byte(($urandom_range(0, 3) == 0) ? dilp_pkg::LongDelayCode
                                              : 8'($urandom_range(0, 255)));
    end
  endtask

  // result side: random ready gaps, one long hold-off to back the block up
  initial begin
    dilp_pkg::result_t got;
    int                gap;
    wait (rst_n === 1'b1);
    forever begin
      if (items_seen == HoldAfter && !hold_done) begin
        gap       = HoldCycles;
        hold_done = 1'b1;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 10);
      end
      @(negedge clk);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.kind      = out_tuser[1:0];
      got.value     = out_tdata;
      got.frame_end = out_tlast;
      got.list_done = out_tuser[2];
      board.check_result(got);
      items_seen++;
    end
  end

  // stimulus
  initial begin
    logic [15:0] delay_settings[5];
    int          pick;
    int          phase_start;
    bytes_sent = 0;
    no_idle    = 1'b0;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    board      = new();
    delay_settings[0] = 16'hFFFF;
    delay_settings[1] = 16'h0000;
    delay_settings[2] = 16'($urandom_range(0, 65535));
    delay_settings[3] = 16'd1;
    delay_settings[4] = 16'($urandom_range(0, 65535));
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed lists under the reset long delay
    send_byte(8'd3);
    send_byte(8'h00); send_byte(8'h00);                  // no args, no delay
    send_byte(8'hFF); send_byte(8'h80); send_byte(8'hFF); // delay only, long delay
    send_byte(8'h2A); send_byte(8'h82);                   // args then short delay
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h00);                                     // empty list
    send_byte(8'd1);
    send_byte(8'h11); send_byte(8'h01); send_byte(8'h55); // one arg, ends list
    send_byte(8'd2);
    send_byte(8'hA5); send_byte(8'h81); send_byte(8'h5A); send_byte(8'h7F);
    send_byte(8'h3C); send_byte(8'h80); send_byte(8'hFE);
    drain_items();

    // random phases, each under its own long delay setting
    for (int p = 0; p < 5; p++) begin
      write_long_delay(delay_settings[p]);
      no_idle     = (p == 2);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseItems) begin
        pick = $urandom_range(0, 11);
        if (pick == 0) begin
          // stray bytes that knock the parser off a clean list boundary
          repeat ($urandom_range(3, 12)) send_byte(8'($urandom_range(0, 255)));
        end else if (pick == 1) begin
          send_byte(8'h00);
        end else begin
          send_random_list($urandom_range(1, 5));
        end
      end
      drain_items();
    end

    no_idle = 1'b0;
    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.owed_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/dilp_pkg.sv
hw/rtl/dilp_parser.sv
hw/rtl/display_init_list_player_top.sv
hw/rtl/dilp_checker.sv
tb/tb_display_init_list_player_top.sv
